@@ hdl/blocked_matrix_multiply_assert.svh @@
// Assertion macros for the blocked matrix multiply engine.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef BLOCKED_MATRIX_MULTIPLY_ASSERT_SVH
`define BLOCKED_MATRIX_MULTIPLY_ASSERT_SVH

`define BMM_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define BMM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hdl/bmm_pkg.sv @@
package bmm_pkg;

  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W = 40;
  localparam int CFG_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BLOCKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_BLOCKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_BLOCKS = 2'd2;
  localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [1:0] {
    FUNC_WRITE_A = 2'd0,
    FUNC_WRITE_B = 2'd1,
    FUNC_COMPUTE = 2'd2,
    FUNC_READ_C  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    func_t                     func;
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        col;
    logic signed [ELEM_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic                     kind;
    logic                     status;
    logic signed [ACC_W-1:0]  product;
  } result_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

@@ hdl/bmm_mac.sv @@
module bmm_mac #(
  parameter int AW = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bmm_pkg::mac_ctl_t                   issue,
  input  logic [AW-1:0]                       issue_addr,
  input  logic signed [bmm_pkg::ELEM_W-1:0]   a_data,
  input  logic signed [bmm_pkg::ELEM_W-1:0]   b_data,
  output logic                                c_we,
  output logic [AW-1:0]                       c_waddr,
  output logic signed [bmm_pkg::ACC_W-1:0]    c_wdata,
  output logic                                busy
);

  bmm_pkg::mac_ctl_t                  s1;
  bmm_pkg::mac_ctl_t                  s2;
  logic [AW-1:0]                      s1_addr;
  logic [AW-1:0]                      s2_addr;
  logic signed [bmm_pkg::PROD_W-1:0]  prod;
  logic signed [bmm_pkg::ACC_W-1:0]   acc;
  logic signed [bmm_pkg::ACC_W-1:0]   sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else begin
      s1 <= issue;
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= issue_addr;
    s2_addr <= s1_addr;
    prod <= a_data * b_data;
    if (s2.valid) begin
      acc <= sum;
    end
  end

  always_comb begin
    sum = (s2.first ? '0 : acc) +
          {{(bmm_pkg::ACC_W - bmm_pkg::PROD_W){prod[bmm_pkg::PROD_W-1]}}, prod};
  end

  assign c_we = s2.valid && s2.last;
  assign c_waddr = s2_addr;
  assign c_wdata = sum;
  assign busy = s1.valid || s2.valid;

endmodule

@@ hdl/blocked_matrix_multiply.sv @@
// Write items give no result; in idle one is accepted every cycle unless a read result waits.
// A read item passes the C read register, then the result register; reads stream one per
// cycle while result_stall is low. A compute item walks rows*cols*inner MACs, one per
// cycle through the A and B memory read ports, and answers once the MAC pipeline drains.
// Reset sets all three block counts to 4 and makes C read as zero until the first compute;
// A and B hold no defined contents until written, and there is no clearing pass.
`include "blocked_matrix_multiply_assert.svh"

module blocked_matrix_multiply #(
  parameter int BLOCK_SIZE = 16,
  parameter int MAX_BLOCKS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  bmm_pkg::item_t                    item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output bmm_pkg::result_t                  result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bmm_pkg::CFG_W-1:0]         cfg_data
);

  localparam int DIM = BLOCK_SIZE * MAX_BLOCKS;
  localparam int DEPTH = DIM * DIM;
  localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DIM + 1);
  localparam int CW = (LW > bmm_pkg::COORD_W) ? LW : bmm_pkg::COORD_W;

  function automatic logic [LW-1:0] limit_of(input logic [bmm_pkg::CFG_W-1:0] r);
    logic [LW-1:0] blocks;
    if (r == '0) begin
      blocks = LW'(1);
    end else if (CW'(r) > CW'(MAX_BLOCKS)) begin
      blocks = LW'(MAX_BLOCKS);
    end else begin
      blocks = LW'(r);
    end
    return LW'(blocks * LW'(BLOCK_SIZE));
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(AW'(r) * AW'(DIM) + AW'(c));
  endfunction

  logic [bmm_pkg::ELEM_W-1:0]        a_mem [DEPTH];
  logic [bmm_pkg::ELEM_W-1:0]        b_mem [DEPTH];
  logic [bmm_pkg::ACC_W-1:0]         c_mem [DEPTH];
  logic signed [bmm_pkg::ELEM_W-1:0] a_rdata;
  logic signed [bmm_pkg::ELEM_W-1:0] b_rdata;
  logic signed [bmm_pkg::ACC_W-1:0]  c_rdata;

  logic [bmm_pkg::CFG_W-1:0] row_blocks;
  logic [bmm_pkg::CFG_W-1:0] col_blocks;
  logic [bmm_pkg::CFG_W-1:0] inner_blocks;

  bmm_pkg::state_t state;
  bmm_pkg::state_t state_next;

  logic [LW-1:0] rows_now;
  logic [LW-1:0] cols_now;
  logic [LW-1:0] inner_now;
  logic [LW-1:0] run_rows;
  logic [LW-1:0] run_cols;
  logic [LW-1:0] run_inner;
  logic          computed;

  logic [IW-1:0] cnt_i;
  logic [IW-1:0] cnt_j;
  logic [IW-1:0] cnt_k;
  logic          i_last;
  logic          j_last;
  logic          k_last;

  logic [CW-1:0] in_row;
  logic [CW-1:0] in_col;
  logic [AW-1:0] in_addr;
  logic          item_accept;
  logic          a_we;
  logic          b_we;
  logic          rd_accept;
  logic          cmp_accept;

  logic          rd_pend;
  logic          rd_bad;
  logic          rd_zero;
  logic          out_free;
  logic          p_move;
  logic          done_load;

  bmm_pkg::mac_ctl_t              issue;
  logic [AW-1:0]                  issue_addr;
  logic                           c_we;
  logic [AW-1:0]                  c_waddr;
  logic signed [bmm_pkg::ACC_W-1:0] c_wdata;
  logic                           mac_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_blocks <= bmm_pkg::CFG_RESET;
      col_blocks <= bmm_pkg::CFG_RESET;
      inner_blocks <= bmm_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bmm_pkg::CFG_ROW_BLOCKS: row_blocks <= cfg_data;
        bmm_pkg::CFG_COL_BLOCKS: col_blocks <= cfg_data;
        bmm_pkg::CFG_INNER_BLOCKS: inner_blocks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign rows_now = limit_of(row_blocks);
  assign cols_now = limit_of(col_blocks);
  assign inner_now = limit_of(inner_blocks);

  assign out_free = !result_valid || !result_stall;
  assign p_move = rd_pend && out_free;
  assign item_stall = (state != bmm_pkg::ST_IDLE) || (rd_pend && !p_move);
  assign item_accept = item_valid && !item_stall;

  assign in_row = CW'(item.row);
  assign in_col = CW'(item.col);
  assign in_addr = addr_of(in_row, in_col);

  assign a_we = item_accept && (item.func == bmm_pkg::FUNC_WRITE_A) &&
                (in_row < CW'(rows_now)) && (in_col < CW'(inner_now));
  assign b_we = item_accept && (item.func == bmm_pkg::FUNC_WRITE_B) &&
                (in_row < CW'(inner_now)) && (in_col < CW'(cols_now));
  assign rd_accept = item_accept && (item.func == bmm_pkg::FUNC_READ_C);
  assign cmp_accept = item_accept && (item.func == bmm_pkg::FUNC_COMPUTE);

  assign i_last = (LW'(cnt_i) + LW'(1)) == run_rows;
  assign j_last = (LW'(cnt_j) + LW'(1)) == run_cols;
  assign k_last = (LW'(cnt_k) + LW'(1)) == run_inner;
  assign issue_addr = addr_of(CW'(cnt_i), CW'(cnt_j));

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[in_addr] <= item.value;
    end
    if (issue.valid) begin
      a_rdata <= a_mem[addr_of(CW'(cnt_i), CW'(cnt_k))];
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[in_addr] <= item.value;
    end
    if (issue.valid) begin
      b_rdata <= b_mem[addr_of(CW'(cnt_k), CW'(cnt_j))];
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    if (rd_accept) begin
      c_rdata <= c_mem[in_addr];
    end
  end

  bmm_mac #(
    .AW(AW)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .issue_addr(issue_addr),
    .a_data    (a_rdata),
    .b_data    (b_rdata),
    .c_we      (c_we),
    .c_waddr   (c_waddr),
    .c_wdata   (c_wdata),
    .busy      (mac_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue = '0;
    done_load = 1'b0;
    unique case (state)
      bmm_pkg::ST_IDLE: begin
        if (cmp_accept) begin
          state_next = bmm_pkg::ST_RUN;
        end
      end
      bmm_pkg::ST_RUN: begin
        issue.valid = 1'b1;
        issue.first = (cnt_k == '0);
        issue.last = k_last;
        if (k_last && j_last && i_last) begin
          state_next = bmm_pkg::ST_DRAIN;
        end
      end
      bmm_pkg::ST_DRAIN: begin
        if (!mac_busy) begin
          state_next = bmm_pkg::ST_DONE;
        end
      end
      bmm_pkg::ST_DONE: begin
        done_load = out_free;
        if (out_free) begin
          state_next = bmm_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state != bmm_pkg::ST_RUN) begin
      cnt_i <= '0;
      cnt_j <= '0;
      cnt_k <= '0;
    end else if (!k_last) begin
      cnt_k <= cnt_k + IW'(1);
    end else begin
      cnt_k <= '0;
      if (!j_last) begin
        cnt_j <= cnt_j + IW'(1);
      end else begin
        cnt_j <= '0;
        cnt_i <= cnt_i + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_accept) begin
      run_rows <= rows_now;
      run_cols <= cols_now;
      run_inner <= inner_now;
    end
    if (rd_accept) begin
      rd_bad <= !((in_row < CW'(rows_now)) && (in_col < CW'(cols_now)));
      rd_zero <= !computed || (in_row >= CW'(run_rows)) || (in_col >= CW'(run_cols));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      computed <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (cmp_accept) begin
        computed <= 1'b1;
      end
      if (rd_accept) begin
        rd_pend <= 1'b1;
      end else if (p_move) begin
        rd_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (p_move || done_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      result.kind <= bmm_pkg::KIND_READ;
      result.status <= rd_bad ? bmm_pkg::STATUS_RANGE : bmm_pkg::STATUS_OK;
      result.product <= (rd_bad || rd_zero) ? '0 : c_rdata;
    end else if (done_load) begin
      result.kind <= bmm_pkg::KIND_DONE;
      result.status <= bmm_pkg::STATUS_OK;
      result.product <= '0;
    end
  end

  `BMM_ASSERT_NOW(a_pend_idle, !(rd_pend && (state != bmm_pkg::ST_IDLE)), "read beat pending while busy")
  `BMM_ASSERT_IMPL(a_cwr_run, c_we, (state == bmm_pkg::ST_RUN) || (state == bmm_pkg::ST_DRAIN), "C write outside compute")
  `BMM_ASSERT_IMPL(a_done_drained, done_load, !mac_busy && !rd_pend, "done beat before pipeline drained")
  `BMM_ASSERT_NOW(a_one_load, !(p_move && done_load), "two result beats loaded at once")

endmodule

@@ tb/sv/blocked_matrix_multiply_tb.sv @@
module blocked_matrix_multiply_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [bmm_pkg::CFG_W-1:0] cfg_data_t;
  typedef logic [bmm_pkg::COORD_W-1:0] coord_t;

  localparam int BLOCK_SIZE = 16;
  localparam int MAX_BLOCKS = 4;
  localparam int DIM = BLOCK_SIZE * MAX_BLOCKS;
  localparam int CELLS = DIM * DIM;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4 * (BLOCK_SIZE * BLOCK_SIZE * BLOCK_SIZE + HOLD_CYCLES);
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_SEGMENTS = 12;
  localparam int SEGMENT_ITEMS = 30;
  localparam int PRESSURE_READS = 40;
  localparam logic [bmm_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  bmm_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  bmm_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bmm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  cfg_data_t cfg_data = '0;

  blocked_matrix_multiply #(
    .BLOCK_SIZE(BLOCK_SIZE),
    .MAX_BLOCKS(MAX_BLOCKS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Engine copy: block count registers, operand stores and the C accumulators.
  cfg_data_t row_blocks_q = bmm_pkg::CFG_RESET;
  cfg_data_t col_blocks_q = bmm_pkg::CFG_RESET;
  cfg_data_t inner_blocks_q = bmm_pkg::CFG_RESET;
  bit signed [bmm_pkg::ELEM_W-1:0] a_elem [CELLS];
  bit signed [bmm_pkg::ELEM_W-1:0] b_elem [CELLS];
  longint c_acc [CELLS];

  // Operand entries written since reset, tracked as the stimulus is planned.
  bit a_loaded [CELLS];
  bit b_loaded [CELLS];

  bmm_pkg::item_t items_to_send [$];
  bmm_pkg::result_t answers_due [$];

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  function automatic int extent(cfg_data_t code);
    if (code == 0) return BLOCK_SIZE;
    if (code > MAX_BLOCKS) return MAX_BLOCKS * BLOCK_SIZE;
    return int'(code) * BLOCK_SIZE;
  endfunction

  function automatic void multiply_all(int rows, int cols, int inner);
    int i, j, k, n;
    longint a;
    for (n = 0; n < CELLS; n++) c_acc[n] = 0;
    for (i = 0; i < rows; i++) begin
      for (k = 0; k < inner; k++) begin
        a = longint'(a_elem[i * DIM + k]);
        for (j = 0; j < cols; j++) begin
          c_acc[i * DIM + j] += a * longint'(b_elem[k * DIM + j]);
        end
      end
    end
  endfunction

  function automatic void engine_accept(bmm_pkg::item_t it);
    int rows, cols, inner, r, c;
    bmm_pkg::result_t ans;
    rows = extent(row_blocks_q);
    cols = extent(col_blocks_q);
    inner = extent(inner_blocks_q);
    r = it.row;
    c = it.col;
    ans = '0;
    case (it.func)
      bmm_pkg::FUNC_WRITE_A: begin
        if (r < rows && c < inner) a_elem[r * DIM + c] = it.value;
      end
      bmm_pkg::FUNC_WRITE_B: begin
        if (r < inner && c < cols) b_elem[r * DIM + c] = it.value;
      end
      bmm_pkg::FUNC_COMPUTE: begin
        multiply_all(rows, cols, inner);
        ans.kind = bmm_pkg::KIND_DONE;
        ans.status = bmm_pkg::STATUS_OK;
        ans.product = '0;
        answers_due.push_back(ans);
      end
      default: begin
        ans.kind = bmm_pkg::KIND_READ;
        if (r < rows && c < cols) begin
          ans.status = bmm_pkg::STATUS_OK;
          ans.product = c_acc[r * DIM + c][bmm_pkg::ACC_W-1:0];
        end else begin
          ans.status = bmm_pkg::STATUS_RANGE;
          ans.product = '0;
        end
        answers_due.push_back(ans);
      end
    endcase
  endfunction

  function automatic void check_answer(bmm_pkg::result_t got);
    bmm_pkg::result_t want;
    if (answers_due.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected result beat: kind %0d status %0d product %0d",
                 got.kind, got.status, got.product);
      mismatches++;
    end else begin
      want = answers_due.pop_front();
      if (got.kind !== want.kind || got.status !== want.status ||
          got.product !== want.product) begin
        if (mismatches < 10)
          $display({"result beat differs: expected kind %0d status %0d product %0d,",
                    " got %0d %0d %0d"},
                   want.kind, want.status, want.product,
                   got.kind, got.status, got.product);
        mismatches++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) engine_accept(item);
      if (!item_valid || !item_stall) begin
        if (items_to_send.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          item <= items_to_send.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) check_answer(result);
      if (holds_served != hold_requests) begin
        holds_served <= hold_requests;
        hold_left <= HOLD_CYCLES;
        result_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("blocked_matrix_multiply: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [bmm_pkg::CFG_IDX_W-1:0] idx, input cfg_data_t data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      bmm_pkg::CFG_ROW_BLOCKS: row_blocks_q = data;
      bmm_pkg::CFG_COL_BLOCKS: col_blocks_q = data;
      bmm_pkg::CFG_INNER_BLOCKS: inner_blocks_q = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_blocks(input cfg_data_t rb, input cfg_data_t cb, input cfg_data_t ib);
    write_reg(bmm_pkg::CFG_ROW_BLOCKS, rb);
    write_reg(bmm_pkg::CFG_COL_BLOCKS, cb);
    write_reg(bmm_pkg::CFG_INNER_BLOCKS, ib);
  endtask

  task automatic set_idling(input int send_gap, input int recv_stall);
    gap_pct = send_gap;
    stall_pct = recv_stall;
  endtask

  task automatic drain();
    do @(negedge clk); while (items_to_send.size() != 0 || item_valid || answers_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_item(input bmm_pkg::func_t f, input int r, input int c,
                            input logic [15:0] v);
    bmm_pkg::item_t it;
    it.func = f;
    it.row = coord_t'(r);
    it.col = coord_t'(c);
    it.value = v;
    case (f)
      bmm_pkg::FUNC_WRITE_A: begin
        if (r < extent(row_blocks_q) && c < extent(inner_blocks_q)) a_loaded[r * DIM + c] = 1'b1;
      end
      bmm_pkg::FUNC_WRITE_B: begin
        if (r < extent(inner_blocks_q) && c < extent(col_blocks_q)) b_loaded[r * DIM + c] = 1'b1;
      end
      default: ;
    endcase
    items_to_send.push_back(it);
  endtask

  // A compute may only touch operands that were written, so the gaps are filled first.
  task automatic load_missing(input bit fixed, input logic [15:0] v);
    int rows, cols, inner, r, c;
    rows = extent(row_blocks_q);
    cols = extent(col_blocks_q);
    inner = extent(inner_blocks_q);
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < inner; c++) begin
        if (!a_loaded[r * DIM + c])
          queue_item(bmm_pkg::FUNC_WRITE_A, r, c, fixed ? v : 16'($urandom));
      end
    end
    for (r = 0; r < inner; r++) begin
      for (c = 0; c < cols; c++) begin
        if (!b_loaded[r * DIM + c])
          queue_item(bmm_pkg::FUNC_WRITE_B, r, c, fixed ? v : 16'($urandom));
      end
    end
  endtask

  function automatic logic [15:0] pick_value();
    if ($urandom_range(0, 9) != 0) return 16'($urandom);
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  function automatic int pick_coord(int limit);
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, limit - 1);
    return $urandom_range(0, DIM - 1);
  endfunction

  function automatic cfg_data_t pick_blocks();
    case ($urandom_range(0, 9))
      0: return 3'd0;
      1, 2, 3, 4: return 3'd1;
      5, 6: return 3'd2;
      7: return 3'd3;
      default: return cfg_data_t'($urandom_range(4, 7));
    endcase
  endfunction

  initial begin
    int seg, n, sel, rows, cols, inner;
    bit may_compute;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_idling(0, 0);
    queue_item(bmm_pkg::FUNC_READ_C, 0, 0, 16'h0000);
    queue_item(bmm_pkg::FUNC_READ_C, DIM - 1, DIM - 1, 16'h0000);
    queue_item(bmm_pkg::FUNC_WRITE_A, DIM - 1, DIM - 1, 16'h7fff);
    drain();

    // Smallest size with every operand at the negative extreme.
    set_blocks(3'd1, 3'd1, 3'd1);
    load_missing(1'b1, 16'h8000);
    queue_item(bmm_pkg::FUNC_COMPUTE, DIM - 1, DIM - 1, 16'hffff);
    queue_item(bmm_pkg::FUNC_READ_C, 0, 0, 16'h0000);
    queue_item(bmm_pkg::FUNC_READ_C, BLOCK_SIZE - 1, BLOCK_SIZE - 1, 16'h0000);
    queue_item(bmm_pkg::FUNC_READ_C, BLOCK_SIZE, 0, 16'h0000);
    queue_item(bmm_pkg::FUNC_READ_C, 0, BLOCK_SIZE, 16'h0000);
    queue_item(bmm_pkg::FUNC_WRITE_A, BLOCK_SIZE, 0, 16'h1234);
    queue_item(bmm_pkg::FUNC_WRITE_A, 0, BLOCK_SIZE, 16'h1234);
    queue_item(bmm_pkg::FUNC_WRITE_B, BLOCK_SIZE, 0, 16'h4321);
    queue_item(bmm_pkg::FUNC_WRITE_B, 0, BLOCK_SIZE, 16'h4321);
    queue_item(bmm_pkg::FUNC_WRITE_A, 0, 0, 16'h7fff);
    queue_item(bmm_pkg::FUNC_COMPUTE, 0, 0, 16'h0000);
    queue_item(bmm_pkg::FUNC_READ_C, 0, 0, 16'h0000);
    queue_item(bmm_pkg::FUNC_READ_C, BLOCK_SIZE - 1, BLOCK_SIZE - 1, 16'h0000);
    drain();

    // Zero counts act as one block, and the unused index is ignored.
    write_reg(CFG_UNUSED_INDEX, 3'd5);
    set_blocks(3'd0, 3'd0, 3'd0);
    queue_item(bmm_pkg::FUNC_COMPUTE, 21, 42, 16'h5555);
    queue_item(bmm_pkg::FUNC_READ_C, BLOCK_SIZE - 1, BLOCK_SIZE - 1, 16'h0000);
    queue_item(bmm_pkg::FUNC_READ_C, BLOCK_SIZE, DIM - 1, 16'h0000);
    drain();

    // Counts above the maximum act as the maximum.
    set_blocks(3'd7, 3'd7, 3'd0);
    queue_item(bmm_pkg::FUNC_WRITE_A, DIM - 1, BLOCK_SIZE - 1, 16'h0101);
    queue_item(bmm_pkg::FUNC_WRITE_B, BLOCK_SIZE - 1, DIM - 1, 16'h0202);
    queue_item(bmm_pkg::FUNC_WRITE_B, BLOCK_SIZE, DIM - 1, 16'h0303);
    queue_item(bmm_pkg::FUNC_READ_C, DIM - 1, DIM - 1, 16'h0000);
    queue_item(bmm_pkg::FUNC_READ_C, 0, DIM - 1, 16'h0000);
    drain();

    for (seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      case ((seg / 2) % 4)
        0: set_idling(0, 0);
        1: set_idling(88, 0);
        2: set_idling(0, 88);
        default: set_idling(32, 32);
      endcase
      if (seg % 2 == 1)
        set_blocks(cfg_data_t'($urandom_range(0, 1)), cfg_data_t'($urandom_range(0, 1)),
                   cfg_data_t'($urandom_range(0, 1)));
      else
        set_blocks(pick_blocks(), pick_blocks(), pick_blocks());
      rows = extent(row_blocks_q);
      cols = extent(col_blocks_q);
      inner = extent(inner_blocks_q);
      may_compute = (rows * cols * inner <= BLOCK_SIZE * BLOCK_SIZE * BLOCK_SIZE);
      if (seg == 0) begin
        hold_requests = hold_requests + 1;
        for (n = 0; n < PRESSURE_READS; n++)
          queue_item(bmm_pkg::FUNC_READ_C, pick_coord(rows), pick_coord(cols), 16'($urandom));
      end
      for (n = 0; n < SEGMENT_ITEMS; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 3 && may_compute) begin
          load_missing(1'b0, '0);
          queue_item(bmm_pkg::FUNC_COMPUTE, $urandom_range(0, DIM - 1),
                     $urandom_range(0, DIM - 1), 16'($urandom));
        end else if (sel < 36) begin
          queue_item(bmm_pkg::FUNC_WRITE_A, pick_coord(rows), pick_coord(inner), pick_value());
        end else if (sel < 69) begin
          queue_item(bmm_pkg::FUNC_WRITE_B, pick_coord(inner), pick_coord(cols), pick_value());
        end else begin
          queue_item(bmm_pkg::FUNC_READ_C, pick_coord(rows), pick_coord(cols), 16'($urandom));
        end
      end
      drain();
    end

    // Back at the reset size, entries outside the last product read as zero.
    set_idling(0, 0);
    set_blocks(bmm_pkg::CFG_RESET, bmm_pkg::CFG_RESET, bmm_pkg::CFG_RESET);
    queue_item(bmm_pkg::FUNC_READ_C, 0, 0, 16'h0000);
    queue_item(bmm_pkg::FUNC_READ_C, DIM - 1, DIM - 1, 16'h0000);
    queue_item(bmm_pkg::FUNC_READ_C, 31, 47, 16'h0000);
    queue_item(bmm_pkg::FUNC_READ_C, DIM - 1, 0, 16'h0000);
    drain();

    if (mismatches == 0 && answers_due.size() == 0)
      $display("blocked_matrix_multiply: match");
    else
      $display("blocked_matrix_multiply: mismatch");
    $finish;
  end

endmodule
